### hw/rtl/pcrg_pkg.sv
// Shared widths, register codes and side-band types for the pinhole camera ray generator.
// No dependencies; every other file of the block imports this package.
package pcrg_pkg;

	localparam int PIX_W   = 20;
	localparam int STEP_W  = 32;
	localparam int PROD_W  = 52;
	localparam int SX_W    = 34;
	localparam int PRD_W   = 50;
	localparam int V_W     = 52;
	localparam int ABS_W   = 51;
	localparam int POS_W   = 6;
	localparam int MAG_W   = 30;
	localparam int SQ_W    = 62;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = 31;
	localparam int NUM_W   = 45;
	localparam int QUO_W   = 15;
	localparam int DIR_W   = 16;
	localparam int REG_W   = 64;
	localparam int ADDR_W  = 6;
	localparam int SQRT_STEPS = 32;

	localparam logic [REG_W-1:0] ROW_X_RST = 64'd16384;
	localparam logic [REG_W-1:0] ROW_Y_RST = 64'd1073741824;
	localparam logic [REG_W-1:0] ROW_Z_RST = 64'd70368744177664;
	localparam logic [QUO_W-1:0] DIR_ONE   = 15'd16384;

	// Register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_ROW_X  = 3'd0,
		REG_ROW_Y  = 3'd1,
		REG_ROW_Z  = 3'd2,
		REG_STEP_X = 3'd3,
		REG_STEP_Y = 3'd4,
		REG_HALF_X = 3'd5,
		REG_HALF_Y = 3'd6
	} reg_idx_t;

	// Normalised magnitudes with their signs, carried beside the root and divide
	typedef struct packed {
		logic [2:0]            neg;
		logic                  zero;
		logic [2:0][MAG_W-1:0] mag;
	} pcrg_side_t;

endpackage

### hw/rtl/pcrg_front.sv
// Screen point and rotation stages: pixel times step minus offset, then R * (sx, sy, 1).
// Depends on pcrg_pkg.
module pcrg_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [pcrg_pkg::PIX_W-1:0]            pixel_x,
	input  logic [pcrg_pkg::PIX_W-1:0]            pixel_y,
	input  logic [2:0][pcrg_pkg::REG_W-1:0]       rows,
	input  logic [pcrg_pkg::STEP_W-1:0]           step_x,
	input  logic [pcrg_pkg::STEP_W-1:0]           step_y,
	input  logic [pcrg_pkg::STEP_W-1:0]           half_x,
	input  logic [pcrg_pkg::STEP_W-1:0]           half_y,
	output logic                                  out_valid,
	output logic signed [pcrg_pkg::V_W-1:0]       vec [3]
);
	import pcrg_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PROD_W-1:0]        prod_x_s1, prod_y_s1;
	logic signed [SX_W-1:0]   sx_s2, sy_s2;
	logic signed [PRD_W-1:0]  p0_s3 [3];
	logic signed [PRD_W-1:0]  p1_s3 [3];
	logic signed [V_W-1:0]    v_s4 [3];
	logic [PROD_W+1:0]        t_x, t_y;

	// Valid bits travel with the data and hold on a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Offset subtraction with rounding half up, kept exact in 54 bits
	always_comb begin
		t_x = {2'b00, prod_x_s1} - {10'd0, half_x, 12'd0} + 54'd524288;
		t_y = {2'b00, prod_y_s1} - {10'd0, half_y, 12'd0} + 54'd524288;
	end

	// Stage 1: products, stage 2: screen point, stage 3: rotation products, stage 4: sums
	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= PROD_W'(pixel_x) * PROD_W'(step_x);
			prod_y_s1 <= PROD_W'(pixel_y) * PROD_W'(step_y);
			sx_s2     <= t_x[PROD_W+1:20];
			sy_s2     <= t_y[PROD_W+1:20];
			for (int i = 0; i < 3; i++) begin
				p0_s3[i] <= $signed(rows[i][15:0]) * sx_s2;
				p1_s3[i] <= $signed(rows[i][31:16]) * sy_s2;
				v_s4[i]  <= V_W'(p0_s3[i]) + V_W'(p1_s3[i])
				            + {{(V_W-32){rows[i][47]}}, rows[i][47:32], 16'd0};
			end
		end
	end

	assign out_valid = vld_s4;
	assign vec       = v_s4;

endmodule

### hw/rtl/pcrg_norm.sv
// Block scaling of the direction magnitudes and the sum of their squares.
// Depends on pcrg_pkg.
module pcrg_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [pcrg_pkg::V_W-1:0]  vec [3],
	output logic                             out_valid,
	output logic [pcrg_pkg::SQ_W-1:0]        radicand,
	output pcrg_pkg::pcrg_side_t             side
);
	import pcrg_pkg::*;

	logic [5:0]              vld_q;
	logic [ABS_W-1:0]        abs_s1 [3];
	logic [ABS_W-1:0]        abs_s2 [3];
	logic [ABS_W-1:0]        abs_s3 [3];
	logic [2:0]              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [ABS_W-1:0]        big_s2;
	logic [POS_W-1:0]        pos_s3;
	logic                    zero_s3, zero_s4, zero_s5, zero_s6;
	logic [MAG_W-1:0]        u_s4 [3];
	logic [MAG_W-1:0]        u_s5 [3];
	logic [MAG_W-1:0]        u_s6 [3];
	logic [2*MAG_W-1:0]      sq_s5 [3];
	logic [SQ_W-1:0]         sum_s6;
	logic [V_W-1:0]          absv [3];
	logic [ABS_W-1:0]        big;
	logic [POS_W-1:0]        pos;
	logic [ABS_W-1:0]        shifted [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	// Magnitudes, largest magnitude and its leading one
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			absv[i] = vec[i][V_W-1] ? V_W'(-vec[i]) : V_W'(vec[i]);
		end
		big = abs_s1[0];
		if (abs_s1[1] > big) begin
			big = abs_s1[1];
		end
		if (abs_s1[2] > big) begin
			big = abs_s1[2];
		end
		pos = '0;
		for (int b = 0; b < ABS_W; b++) begin
			if (big_s2[b]) begin
				pos = POS_W'(b);
			end
		end
		// Shift so that the largest lands in [2^29, 2^30)
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= POS_W'(MAG_W-1)) begin
				shifted[i] = abs_s3[i] >> (pos_s3 - POS_W'(MAG_W-1));
			end else begin
				shifted[i] = abs_s3[i] << (POS_W'(MAG_W-1) - pos_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				abs_s1[i] <= absv[i][ABS_W-1:0];
				abs_s2[i] <= abs_s1[i];
				abs_s3[i] <= abs_s2[i];
				u_s4[i]   <= shifted[i][MAG_W-1:0];
				u_s5[i]   <= u_s4[i];
				u_s6[i]   <= u_s5[i];
				sq_s5[i]  <= (2*MAG_W)'(u_s4[i]) * (2*MAG_W)'(u_s4[i]);
				neg_s1[i] <= vec[i][V_W-1];
			end
			big_s2  <= big;
			pos_s3  <= pos;
			zero_s3 <= (big_s2 == '0);
			zero_s4 <= zero_s3;
			zero_s5 <= zero_s4;
			zero_s6 <= zero_s5;
			neg_s2  <= neg_s1;
			neg_s3  <= neg_s2;
			neg_s4  <= neg_s3;
			neg_s5  <= neg_s4;
			neg_s6  <= neg_s5;
			sum_s6  <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
		end
	end

	assign out_valid = vld_q[5];
	assign radicand  = sum_s6;
	always_comb begin
		side.neg  = neg_s6;
		side.zero = zero_s6;
		for (int i = 0; i < 3; i++) begin
			side.mag[i] = u_s6[i];
		end
	end

endmodule

### hw/rtl/pcrg_isqrt.sv
// Digit-by-digit integer square root, one result bit per pipeline stage.
// Depends on pcrg_pkg.
module pcrg_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [pcrg_pkg::SQ_W-1:0]     radicand,
	input  pcrg_pkg::pcrg_side_t          in_side,
	output logic                          out_valid,
	output logic [pcrg_pkg::ROOT_W-1:0]   root,
	output pcrg_pkg::pcrg_side_t          out_side
);
	import pcrg_pkg::*;

	logic             vld_s  [SQRT_STEPS+1];
	logic [RAD_W-1:0] rem_s  [SQRT_STEPS+1];
	logic [RAD_W-1:0] root_s [SQRT_STEPS+1];
	pcrg_side_t       side_s [SQRT_STEPS+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = RAD_W'(radicand);
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (62 - 2*k);
		logic [RAD_W-1:0] trial;

		assign trial = root_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		// Subtract the trial value where it fits and set this root bit
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign root      = root_s[SQRT_STEPS][ROOT_W-1:0];
	assign out_side  = side_s[SQRT_STEPS];

endmodule

### hw/rtl/pcrg_div.sv
// Rounded division of each magnitude by the length, one quotient bit per stage, then sign.
// Depends on pcrg_pkg.
module pcrg_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [pcrg_pkg::ROOT_W-1:0]        root,
	input  pcrg_pkg::pcrg_side_t               in_side,
	output logic                               out_valid,
	output logic [2:0][pcrg_pkg::DIR_W-1:0]    dir
);
	import pcrg_pkg::*;

	logic                    vld_s  [QUO_W+2];
	logic [ROOT_W-1:0]       rt_s   [QUO_W+1];
	pcrg_side_t              side_s [QUO_W+1];
	logic [2:0][NUM_W-1:0]   rem_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0]   quo_s  [QUO_W+1];
	logic [2:0][DIR_W-1:0]   dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QUO_W+2; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < QUO_W+2; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	// Numerator with half the divisor added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0]   <= root;
			side_s[0] <= in_side;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= {1'b0, in_side.mag[i], 14'd0} + NUM_W'(root >> 1);
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_bit
		localparam int SH = QUO_W - 1 - j;
		logic [NUM_W:0] dsh;
		logic [NUM_W:0] diff [3];

		always_comb begin
			dsh = (NUM_W+1)'(rt_s[j]) << SH;
			for (int i = 0; i < 3; i++) begin
				diff[i] = {1'b0, rem_s[j][i]} - dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[j+1]   <= rt_s[j];
				side_s[j+1] <= side_s[j];
				for (int i = 0; i < 3; i++) begin
					if (!diff[i][NUM_W]) begin
						rem_s[j+1][i] <= diff[i][NUM_W-1:0];
					end else begin
						rem_s[j+1][i] <= rem_s[j][i];
					end
					quo_s[j+1][i] <= {quo_s[j][i][QUO_W-2:0], ~diff[i][NUM_W]};
				end
			end
		end
	end

	// Saturate to one, apply the sign, force zero for a zero vector
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [QUO_W-1:0] d;
				d = (quo_s[QUO_W][i] > DIR_ONE) ? DIR_ONE : quo_s[QUO_W][i];
				if (side_s[QUO_W].zero) begin
					dir_q[i] <= '0;
				end else if (side_s[QUO_W].neg[i]) begin
					dir_q[i] <= DIR_W'(-{1'b0, d});
				end else begin
					dir_q[i] <= {1'b0, d};
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W+1];
	assign dir       = dir_q;

endmodule

### hw/rtl/pinhole_camera_ray_generation.sv
// Top level of the pinhole camera ray generator: APB registers, pipeline and output skid stage.
// Depends on pcrg_pkg, pcrg_front, pcrg_norm, pcrg_isqrt and pcrg_div.
//
// channel   | handshake              | payload
// s_*       | tvalid / tready        | tdata: pixel_x, pixel_y
// m_*       | tvalid / tready        | tdata: origin_x/y/z, dir_x/y/z
// APB       | psel, penable, pwrite  | paddr 8*index, pwdata / prdata 64 bits
//
// One sample is accepted every cycle while s_tready is high; each sample passes 60 register
// stages (4 front, 6 scaling, 32 square root, 17 divide and sign, 1 output) before its ray
// is offered on m_*.
// Reset clears all valid bits and loads the identity rotation, zero step and offset.
// A stalled output holds one ray in the output register and one in the skid stage;
// s_tready drops only while the skid stage is full, and the whole pipeline then holds.
module pinhole_camera_ray_generation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,   // pixel_x [19:0], pixel_y [39:20]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [95:0]                   m_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcrg_pkg::ADDR_W-1:0]   paddr,
	input  logic [pcrg_pkg::REG_W-1:0]    pwdata,
	output logic [pcrg_pkg::REG_W-1:0]    prdata,
	output logic                          pready
);
	import pcrg_pkg::*;

	logic [2:0][REG_W-1:0]   rows_q;
	logic [STEP_W-1:0]       step_x_q, step_y_q, half_x_q, half_y_q;
	logic                    en;
	logic                    f_vld, n_vld, r_vld, d_vld;
	logic signed [V_W-1:0]   vec [3];
	logic [SQ_W-1:0]         radicand;
	pcrg_side_t              n_side, r_side;
	logic [ROOT_W-1:0]       root;
	logic [2:0][DIR_W-1:0]   dir;
	logic [95:0]             ray;
	logic                    out_v_q, skid_v_q;
	logic [95:0]             out_q, skid_q;
	logic                    pop, push;
	reg_idx_t                idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW_X_RST;
			rows_q[1] <= ROW_Y_RST;
			rows_q[2] <= ROW_Z_RST;
			step_x_q  <= '0;
			step_y_q  <= '0;
			half_x_q  <= '0;
			half_y_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ROW_X:  rows_q[0] <= pwdata;
				REG_ROW_Y:  rows_q[1] <= pwdata;
				REG_ROW_Z:  rows_q[2] <= pwdata;
				REG_STEP_X: step_x_q  <= pwdata[STEP_W-1:0];
				REG_STEP_Y: step_y_q  <= pwdata[STEP_W-1:0];
				REG_HALF_X: half_x_q  <= pwdata[STEP_W-1:0];
				REG_HALF_Y: half_y_q  <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (idx)
			REG_ROW_X:  prdata = rows_q[0];
			REG_ROW_Y:  prdata = rows_q[1];
			REG_ROW_Z:  prdata = rows_q[2];
			REG_STEP_X: prdata = REG_W'(step_x_q);
			REG_STEP_Y: prdata = REG_W'(step_y_q);
			REG_HALF_X: prdata = REG_W'(half_x_q);
			REG_HALF_Y: prdata = REG_W'(half_y_q);
			default:    prdata = '0;
		endcase
	end

	// The pipeline moves whenever the skid stage has room
	assign en       = ~skid_v_q;
	assign s_tready = en;

	pcrg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.pixel_x  (s_tdata[19:0]),
		.pixel_y  (s_tdata[39:20]),
		.rows     (rows_q),
		.step_x   (step_x_q),
		.step_y   (step_y_q),
		.half_x   (half_x_q),
		.half_y   (half_y_q),
		.out_valid(f_vld),
		.vec      (vec)
	);

	pcrg_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_vld),
		.vec      (vec),
		.out_valid(n_vld),
		.radicand (radicand),
		.side     (n_side)
	);

	pcrg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (n_vld),
		.radicand (radicand),
		.in_side  (n_side),
		.out_valid(r_vld),
		.root     (root),
		.out_side (r_side)
	);

	pcrg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_vld),
		.root     (root),
		.in_side  (r_side),
		.out_valid(d_vld),
		.dir      (dir)
	);

	assign ray = {dir[2], dir[1], dir[0], rows_q[2][63:48], rows_q[1][63:48], rows_q[0][63:48]};

	// Output register with a skid stage behind it
	assign pop  = out_v_q & m_tready;
	assign push = d_vld & ~skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_q <= ray;
			end else begin
				skid_q <= ray;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// The skid stage only ever holds a beat behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output register empty");

	// The skid stage fills only when the output beat was not taken
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid stage filled without an output stall");

	// A finished ray at the pipeline end is held while the pipeline is stopped
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(d_vld && !en) |=> d_vld)
		else $error("ray lost at the end of the pipeline");

	// The x and z directions never exceed unit magnitude
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(out_q[63:48]) <= 16384 && $signed(out_q[63:48]) >= -16384
		          && $signed(out_q[95:80]) <= 16384 && $signed(out_q[95:80]) >= -16384))
		else $error("direction component out of range");

endmodule
